// ----- design/lir_pkg.sv -----
package lir_pkg;

  localparam int SAMPLE_W = 16;
  localparam int STEP_W   = 19;
  localparam int PH_W     = 20;
  localparam int FRAC_W   = 16;
  localparam int PROD_W   = 34;
  localparam int ADDR_W   = 3;

  localparam logic [PH_W-1:0]   ONE_PHASE = 20'h10000;
  localparam logic [STEP_W-1:0] MIN_STEP  = 19'd5461;

  localparam logic [STEP_W-1:0] STEP_RESET   = 19'd65536;
  localparam logic              STEREO_RESET = 1'b1;

  typedef enum logic {
    REG_PHASE_STEP = 1'b0,
    REG_STEREO     = 1'b1
  } reg_idx_t;

  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_RUN  = 1'b1
  } state_t;

  typedef struct packed {
    logic load_push;
    logic load_flush;
    logic issue;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic below_one;
    logic stall;
  } sts_t;

  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [18:0] v);
    if (v > 19'sd32767) begin
      return 16'sh7fff;
    end else if (v < -19'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[SAMPLE_W-1:0];
    end
  endfunction

endpackage

// ----- design/lir_if.sv -----
interface lir_in_if;
  logic              valid;
  logic              ready;
  logic              op;
  logic signed [15:0] in_left;
  logic signed [15:0] in_right;

  modport source(output valid, op, in_left, in_right, input ready);
  modport sink(input valid, op, in_left, in_right, output ready);
endinterface

interface lir_out_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] out_left;
  logic signed [15:0] out_right;
  logic              last;

  modport source(output valid, out_left, out_right, last, input ready);
  modport sink(input valid, out_left, out_right, last, output ready);
endinterface

// ----- design/linear_interp_resampler.sv -----
// An input item's first output frame passes through the run state, the
// product register and the output register. An input frame makes 0..13
// outputs, one per cycle through a multiply stage and a registered output;
// back-pressure stalls the issue loop. Items are taken only while idle.
// Reset (rst, synchronous): phase 0, history 0, priming on, phase_step 65536,
// stereo_input 1, no output pending.
module linear_interp_resampler (
  input  logic                        clk,
  input  logic                        rst,
  lir_in_if.sink                      in_ch,
  lir_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lir_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import lir_pkg::*;

  logic [STEP_W-1:0] phase_step;
  logic              stereo_input;
  logic              cfg_wr;
  reg_idx_t          reg_idx;
  cmd_t              cmd;
  sts_t              sts;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step   <= STEP_RESET;
      stereo_input <= STEREO_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_PHASE_STEP: phase_step   <= pwdata[STEP_W-1:0];
        REG_STEREO:     stereo_input <= pwdata[0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PHASE_STEP: prdata = {{(32-STEP_W){1'b0}}, phase_step};
      REG_STEREO:     prdata = {31'b0, stereo_input};
      default:        prdata = '0;
    endcase
  end

  lir_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lir_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .phase_step   (phase_step),
    .stereo_input (stereo_input),
    .in_left      (in_ch.in_left),
    .in_right     (in_ch.in_right),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_left     (out_ch.out_left),
    .out_right    (out_ch.out_right),
    .out_last     (out_ch.last)
  );

endmodule

// ----- design/lir_ctrl.sv -----
module lir_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_op,
  output logic          in_ready,
  input  lir_pkg::sts_t sts,
  output lir_pkg::cmd_t cmd
);
  import lir_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_op == OP_PUSH) state_next = S_RUN;
      end
      S_RUN: begin
        if (!sts.stall && !sts.below_one) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready       = 1'b1;
        cmd.load_push  = in_valid && in_op == OP_PUSH;
        cmd.load_flush = in_valid && in_op == OP_FLUSH;
      end
      S_RUN: begin
        // one output frame issued per cycle while the phase is below one and the output is not stalled
        cmd.issue  = !sts.stall && sts.below_one;
        cmd.finish = !sts.stall && !sts.below_one;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  a_no_accept_in_run: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> !in_ready)
    else $error("input taken while frame in progress");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $countones(cmd) <= 1)
    else $error("more than one command at once");

  a_finish_to_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> state == S_IDLE)
    else $error("finish did not return to idle");

endmodule

// ----- design/lir_dp.sv -----
module lir_dp (
  input  logic                                     clk,
  input  logic                                     rst,
  input  lir_pkg::cmd_t                            cmd,
  output lir_pkg::sts_t                            sts,
  input  logic        [lir_pkg::STEP_W-1:0]        phase_step,
  input  logic                                     stereo_input,
  input  logic signed [lir_pkg::SAMPLE_W-1:0]      in_left,
  input  logic signed [lir_pkg::SAMPLE_W-1:0]      in_right,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [lir_pkg::SAMPLE_W-1:0]      out_left,
  output logic signed [lir_pkg::SAMPLE_W-1:0]      out_right,
  output logic                                     out_last
);
  import lir_pkg::*;

  logic        [STEP_W-1:0]   phase;
  logic        [PH_W-1:0]     ph;
  logic                       need_prime;
  logic signed [SAMPLE_W-1:0] cur_l;
  logic signed [SAMPLE_W-1:0] cur_r;
  logic signed [SAMPLE_W-1:0] prev_l;
  logic signed [SAMPLE_W-1:0] prev_r;

  logic signed [PROD_W-1:0]   prod_l;
  logic signed [PROD_W-1:0]   prod_r;
  logic                       p_valid;
  logic                       p_last;

  logic        [STEP_W-1:0]   step;
  logic        [PH_W-1:0]     ph_add;
  logic signed [SAMPLE_W-1:0] sel_r;
  logic signed [SAMPLE_W:0]   diff_l;
  logic signed [SAMPLE_W:0]   diff_r;
  logic signed [FRAC_W:0]     frac;
  logic signed [18:0]         sum_l;
  logic signed [18:0]         sum_r;
  logic                       stall;

  assign step   = (phase_step < MIN_STEP) ? MIN_STEP : phase_step;
  assign ph_add = ph + {1'b0, step};
  assign sel_r  = stereo_input ? in_right : in_left;
  assign diff_l = {cur_l[SAMPLE_W-1], cur_l} - {prev_l[SAMPLE_W-1], prev_l};
  assign diff_r = {cur_r[SAMPLE_W-1], cur_r} - {prev_r[SAMPLE_W-1], prev_r};
  assign frac   = $signed({1'b0, ph[FRAC_W-1:0]});

  // prev + floor(diff * frac / 65536): arithmetic shift of the product
  assign sum_l = {{3{prev_l[SAMPLE_W-1]}}, prev_l}
               + {prod_l[PROD_W-1], prod_l[PROD_W-1:FRAC_W]};
  assign sum_r = {{3{prev_r[SAMPLE_W-1]}}, prev_r}
               + {prod_r[PROD_W-1], prod_r[PROD_W-1:FRAC_W]};

  assign stall         = out_valid && !out_ready;
  assign sts.stall     = stall;
  assign sts.below_one = ph < ONE_PHASE;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= '0;
      need_prime <= 1'b1;
      prev_l     <= '0;
      prev_r     <= '0;
    end else begin
      if (cmd.load_flush) begin
        phase      <= '0;
        need_prime <= 1'b1;
      end
      if (cmd.load_push) begin
        need_prime <= 1'b0;
        if (need_prime) begin
          prev_l <= in_left;
          prev_r <= sel_r;
        end
      end
      if (cmd.finish) begin
        phase  <= STEP_W'(ph - ONE_PHASE);
        prev_l <= cur_l;
        prev_r <= cur_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_push) begin
      cur_l <= in_left;
      cur_r <= sel_r;
      ph    <= {1'b0, phase};
    end else if (cmd.issue) begin
      ph <= ph_add;
    end
    if (cmd.issue) begin
      prod_l <= PROD_W'(diff_l) * PROD_W'(frac);
      prod_r <= PROD_W'(diff_r) * PROD_W'(frac);
      p_last <= ph_add >= ONE_PHASE;
    end
    if (!stall && p_valid) begin
      out_left  <= sat16(sum_l);
      out_right <= sat16(sum_r);
      out_last  <= p_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!stall) begin
        p_valid   <= cmd.issue;
        out_valid <= p_valid;
      end
    end
  end

  a_issue_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> !stall && ph < ONE_PHASE)
    else $error("issue while stalled or phase past one");

  a_prod_held: assert property (@(posedge clk) disable iff (rst)
    p_valid && stall |=> p_valid)
    else $error("product dropped during stall");

  a_finish_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> ph >= ONE_PHASE)
    else $error("finish with phase below one");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.load_flush |=> need_prime && phase == '0)
    else $error("flush did not clear phase");

endmodule

// ----- verif/resampler_checker.sv -----
`timescale 1ns / 1ps

module resampler_checker (
  input  logic                       clk,
  input  logic                       rst,
  lir_in_if                          in_mon,
  lir_out_if                         out_mon,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [lir_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output int                         mismatches,
  output int                         frames_pending,
  output int                         frames_checked
);
  import lir_pkg::*;

  localparam int MAX_FRAMES = 13;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               last;
  } out_frame_t;

  out_frame_t frames_expected[$];

  // shadow of the register file and of the resampler state
  logic [STEP_W-1:0]  step_cfg;
  logic               stereo_cfg;
  logic [STEP_W-1:0]  phase;
  logic signed [15:0] prev_l;
  logic signed [15:0] prev_r;
  logic               need_prime;

  // prev + floor((cur - prev) * frac / 2^16), clamped to 16 bits
  function automatic logic signed [15:0] blend(input logic signed [15:0] prev,
                                               input logic signed [15:0] cur,
                                               input logic [15:0] frac);
    logic signed [16:0] diff;
    logic signed [33:0] prod;
    logic signed [18:0] sum;
    diff = 17'(cur) - 17'(prev);
    prod = 34'(diff) * 34'($signed({1'b0, frac}));
    sum = 19'(prev + (prod >>> 16));
    if (sum > 19'sd32767) begin
      return 16'sh7fff;
    end else if (sum < -19'sd32768) begin
      return 16'sh8000;
    end
    return sum[15:0];
  endfunction

  task automatic resample_frame(input op_t op, input logic signed [15:0] l_in,
                                input logic signed [15:0] r_in);
    logic signed [15:0] cur_l;
    logic signed [15:0] cur_r;
    logic [STEP_W-1:0]  step;
    logic [PH_W-1:0]    ph;
    logic [PH_W-1:0]    nxt;
    int                 n;
    out_frame_t         f;
    if (op == OP_FLUSH) begin
      phase = '0;
      need_prime = 1'b1;
      return;
    end
    cur_l = l_in;
    cur_r = stereo_cfg ? r_in : l_in;
    if (need_prime) begin
      prev_l = cur_l;
      prev_r = cur_r;
      need_prime = 1'b0;
    end
    step = (step_cfg < MIN_STEP) ? MIN_STEP : step_cfg;
    ph = {1'b0, phase};
    n = 0;
    while (ph < ONE_PHASE && n < MAX_FRAMES) begin
      nxt = ph + {1'b0, step};
      f.left = blend(prev_l, cur_l, ph[15:0]);
      f.right = blend(prev_r, cur_r, ph[15:0]);
      f.last = !(nxt < ONE_PHASE && n + 1 < MAX_FRAMES);
      frames_expected.push_back(f);
      n++;
      ph = nxt;
    end
    phase = STEP_W'(ph - ONE_PHASE);
    prev_l = cur_l;
    prev_r = cur_r;
  endtask

  initial begin
    mismatches = 0;
    frames_pending = 0;
    frames_checked = 0;
  end

  always @(posedge clk) begin
    out_frame_t f;
    if (rst) begin
      step_cfg = STEP_RESET;
      stereo_cfg = STEREO_RESET;
      phase = '0;
      prev_l = '0;
      prev_r = '0;
      need_prime = 1'b1;
      frames_expected.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (reg_idx_t'(paddr[2]) == REG_PHASE_STEP) begin
          step_cfg = pwdata[STEP_W-1:0];
        end else if (reg_idx_t'(paddr[2]) == REG_STEREO) begin
          stereo_cfg = pwdata[0];
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        resample_frame(op_t'(in_mon.op), in_mon.in_left, in_mon.in_right);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (frames_expected.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected output frame L=%0d R=%0d last=%0b", $time,
                   out_mon.out_left, out_mon.out_right, out_mon.last);
        end else begin
          f = frames_expected.pop_front();
          frames_checked++;
          if (out_mon.out_left !== f.left || out_mon.out_right !== f.right ||
              out_mon.last !== f.last) begin
            mismatches++;
            $display({"%0t: frame mismatch: expected L=%0d R=%0d last=%0b, ",
                      "got L=%0d R=%0d last=%0b"},
                     $time, f.left, f.right, f.last,
                     out_mon.out_left, out_mon.out_right, out_mon.last);
          end
        end
      end
    end
    frames_pending = frames_expected.size();
  end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import lir_pkg::*;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  lir_in_if  in_ch();
  lir_out_if out_ch();

  int mismatches;
  int frames_pending;
  int frames_checked;

  // no idle gaps on either side once set
  bit calm = 1'b0;
  int items_sent = 0;
  int flushes_sent = 0;
  int settings_used = 0;

  linear_interp_resampler dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  resampler_checker frame_checker (
    .clk           (clk),
    .rst           (rst),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .mismatches    (mismatches),
    .frames_pending(frames_pending),
    .frames_checked(frames_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("%0t: timeout, %0d frames still expected", $time, frames_pending);
    $display("** linear_interp_resampler: FAILED **");
    $finish;
  end

  // output side: random stall bursts
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return '0;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] pick_step();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return MIN_STEP - 1'b1;
      2: return MIN_STEP;
      3: return 19'd65536;
      4: return 19'd262144;
      5: return '1;
      6: return STEP_W'($urandom_range(5461, 262144));
      default: return STEP_W'($urandom);
    endcase
  endfunction

  task automatic push_item(input op_t op, input logic signed [15:0] l,
                           input logic signed [15:0] r);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.in_left <= l;
    in_ch.in_right <= r;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    if (op == OP_FLUSH) flushes_sent++;
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // wait until every frame is out, plus slack for items that make none
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (frames_pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_config(input logic [STEP_W-1:0] step, input logic stereo);
    drain();
    write_reg(REG_PHASE_STEP, {13'($urandom), step});
    write_reg(REG_STEREO, {31'($urandom), stereo});
    settings_used++;
  endtask

  initial begin
    int waited;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.op <= OP_PUSH;
    in_ch.in_left <= '0;
    in_ch.in_right <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: one frame out per frame in, then a flush
    push_item(OP_PUSH, 16'sh7fff, 16'sh8000);
    push_item(OP_PUSH, 16'sh8000, 16'sh7fff);
    push_item(OP_FLUSH, pick_sample(), pick_sample());

    // step below range gets clamped: up to 13 frames per input, full swing
    set_config('0, 1'b1);
    push_item(OP_PUSH, 16'sh8000, 16'sh7fff);
    push_item(OP_PUSH, 16'sh7fff, 16'sh8000);
    push_item(OP_PUSH, 16'sh8000, 16'sh7fff);
    push_item(OP_PUSH, -16'sd1, 16'sd1);
    push_item(OP_FLUSH, pick_sample(), pick_sample());
    push_item(OP_FLUSH, pick_sample(), pick_sample());
    push_item(OP_PUSH, 16'sd12345, -16'sd12345);
    push_item(OP_PUSH, 16'sh8000, 16'sh8000);

    // mono: right input ignored
    set_config(MIN_STEP - 1'b1, 1'b0);
    push_item(OP_PUSH, 16'sh7fff, 16'sh1234);
    push_item(OP_PUSH, 16'sh8000, -16'sd1);
    push_item(OP_PUSH, 16'sd100, 16'sh7fff);

    // largest step: after the first input, phase stays above one for several inputs, which make no frames
    set_config('1, 1'b1);
    repeat (8) push_item(OP_PUSH, pick_sample(), pick_sample());

    for (int blk = 0; blk < 6; blk++) begin
      case (blk)
        0: set_config(MIN_STEP, 1'b1);
        1: set_config(19'd262144, 1'b0);
        default: set_config(pick_step(), 1'($urandom));
      endcase
      if (blk == 5) calm = 1'b1;
      repeat (85) begin
        push_item(($urandom_range(0, 19) == 0) ? OP_FLUSH : OP_PUSH,
                  pick_sample(), pick_sample());
      end
    end
    in_ch.valid <= 1'b0;

    waited = 0;
    while (frames_pending != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (16) @(posedge clk);

    $display("Sent %0d input items (%0d flushes) under %0d register settings;",
             items_sent, flushes_sent, settings_used);
    $display("compared %0d output frames, %0d mismatches.", frames_checked, mismatches);
    if (frames_pending != 0) begin
      $display("%0t: %0d expected frames never came out", $time, frames_pending);
    end
    if (mismatches == 0 && frames_pending == 0) begin
      $display("** linear_interp_resampler: PASSED **");
    end else begin
      $display("** linear_interp_resampler: FAILED **");
    end
    $finish;
  end

endmodule
